// ----- rtl/bmhq_pkg.sv -----
// Shared types and constants for the binary min-heap queue core.
// Holds the item structs, the status codes and the controller/datapath interface.
// No dependencies.
package bmhq_pkg;

  localparam int unsigned IN_COORD_W = 16;
  localparam int unsigned IN_COST_W  = 32;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned COUNT_W    = 11;

  localparam logic REQ_PUSH = 1'b0;
  localparam logic REQ_POP  = 1'b1;

  localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic                  req_type;
    logic [IN_COORD_W-1:0] point_x;
    logic [IN_COORD_W-1:0] point_y;
    logic [IN_COORD_W-1:0] point_z;
    logic [IN_COST_W-1:0]  point_cost;
  } in_item_t;

  typedef struct packed {
    logic [IN_COORD_W-1:0] out_x;
    logic [IN_COORD_W-1:0] out_y;
    logic [IN_COORD_W-1:0] out_z;
    logic [IN_COST_W-1:0]  out_cost;
    logic [STATUS_W-1:0]   status;
    logic [COUNT_W-1:0]    count_after;
    logic                  is_empty;
  } out_item_t;

  typedef struct packed {
    logic take_push;
    logic take_pop;
    logic take_reject;
    logic rd_parent;
    logic move_up;
    logic pop_last;
    logic load_last;
    logic rd_left;
    logic rd_right;
    logic move_down;
    logic place;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic req_pop;
    logic full;
    logic empty;
    logic at_root;
    logic up_swap;
    logic has_left;
    logic down_swap;
  } sts_t;

endpackage

// ----- rtl/bmhq_ram.sv -----
// Generic simple dual-port RAM with one write port and one registered read port.
// No dependencies.
module bmhq_ram #(
  parameter int unsigned DATA_W = 80,
  parameter int unsigned DEPTH  = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [DATA_W-1:0]        wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [DATA_W-1:0]        rdata
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/bmhq_ctrl.sv -----
// Controller state machine for the binary min-heap queue core.
// Sequences pushes, pops and sifts; depends on bmhq_pkg.
module bmhq_ctrl
  import bmhq_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [9:0] {
    S_IDLE     = 10'b00_0000_0001,
    S_UP_CHK   = 10'b00_0000_0010,
    S_UP_CMP   = 10'b00_0000_0100,
    S_POP_LAST = 10'b00_0000_1000,
    S_POP_LOAD = 10'b00_0001_0000,
    S_DN_RDL   = 10'b00_0010_0000,
    S_DN_RDR   = 10'b00_0100_0000,
    S_DN_CMP   = 10'b00_1000_0000,
    S_DONE     = 10'b01_0000_0000,
    S_SPARE    = 10'b10_0000_0000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          if (sts.req_pop) begin
            if (sts.empty) begin
              cmd.take_reject = 1'b1;
              state_nxt       = S_DONE;
            end else begin
              cmd.take_pop = 1'b1;
              state_nxt    = S_POP_LAST;
            end
          end else if (sts.full) begin
            cmd.take_reject = 1'b1;
            state_nxt       = S_DONE;
          end else begin
            cmd.take_push = 1'b1;
            state_nxt     = S_UP_CHK;
          end
        end
      end
      S_UP_CHK: begin
        if (sts.at_root) begin
          cmd.place = 1'b1;
          state_nxt = S_DONE;
        end else begin
          cmd.rd_parent = 1'b1;
          state_nxt     = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        if (sts.up_swap) begin
          cmd.move_up = 1'b1;
          state_nxt   = S_UP_CHK;
        end else begin
          cmd.place = 1'b1;
          state_nxt = S_DONE;
        end
      end
      S_POP_LAST: begin
        cmd.pop_last = 1'b1;
        state_nxt    = S_POP_LOAD;
      end
      S_POP_LOAD: begin
        cmd.load_last = 1'b1;
        state_nxt     = S_DN_RDL;
      end
      S_DN_RDL: begin
        if (sts.has_left) begin
          cmd.rd_left = 1'b1;
          state_nxt   = S_DN_RDR;
        end else begin
          cmd.place = 1'b1;
          state_nxt = S_DONE;
        end
      end
      S_DN_RDR: begin
        cmd.rd_right = 1'b1;
        state_nxt    = S_DN_CMP;
      end
      S_DN_CMP: begin
        if (sts.down_swap) begin
          cmd.move_down = 1'b1;
          state_nxt     = S_DN_RDL;
        end else begin
          cmd.place = 1'b1;
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        cmd.finish = 1'b1;
        state_nxt  = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/bmhq_dp.sv -----
// Datapath for the binary min-heap queue core: heap memory, count, sift registers
// and the result register. Depends on bmhq_pkg and bmhq_ram.
module bmhq_dp
  import bmhq_pkg::*;
#(
  parameter int unsigned CAPACITY    = 1024,
  parameter int unsigned COORD_WIDTH = 16,
  parameter int unsigned COST_WIDTH  = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  input  in_item_t  in_item,
  input  cmd_t      cmd,
  output sts_t      sts,
  output logic      out_valid,
  output out_item_t out_item
);

  localparam int unsigned IDX_W = $clog2(CAPACITY);
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned CHD_W = CNT_W + 1;
  localparam int unsigned ENT_W = 3 * COORD_WIDTH + COST_WIDTH;
  localparam int unsigned Z_LSB = COST_WIDTH;
  localparam int unsigned Y_LSB = COST_WIDTH + COORD_WIDTH;
  localparam int unsigned X_LSB = COST_WIDTH + 2 * COORD_WIDTH;

  logic [CNT_W-1:0]    count_r;
  logic [IDX_W-1:0]    pos_r;
  logic [ENT_W-1:0]    mover_r;
  logic [ENT_W-1:0]    child_r;
  logic [ENT_W-1:0]    res_ent_r;
  logic [STATUS_W-1:0] res_code_r;
  logic                out_valid_r;
  out_item_t           out_item_r;

  logic [ENT_W-1:0] rdata;
  logic [ENT_W-1:0] wdata;
  logic [ENT_W-1:0] new_ent;
  logic [ENT_W-1:0] pick_ent;
  logic [IDX_W-1:0] raddr;
  logic [IDX_W-1:0] parent;
  logic [IDX_W-1:0] pick_idx;
  logic [CHD_W-1:0] left;
  logic [CHD_W-1:0] right;
  logic             has_right;
  logic             pick_right;
  logic             we;

  bmhq_ram #(
    .DATA_W (ENT_W),
    .DEPTH  (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (pos_r),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign new_ent = {COORD_WIDTH'(in_item.point_x), COORD_WIDTH'(in_item.point_y),
                    COORD_WIDTH'(in_item.point_z), COST_WIDTH'(in_item.point_cost)};

  assign parent    = (pos_r - IDX_W'(1)) >> 1;
  assign left      = CHD_W'({pos_r, 1'b1});
  assign right     = left + CHD_W'(1);
  assign has_right = right < CHD_W'(count_r);

  assign pick_right = has_right && (rdata[COST_WIDTH-1:0] < child_r[COST_WIDTH-1:0]);
  assign pick_ent   = pick_right ? rdata : child_r;
  assign pick_idx   = pick_right ? right[IDX_W-1:0] : left[IDX_W-1:0];

  assign sts.req_pop   = (in_item.req_type == REQ_POP);
  assign sts.full      = (count_r == CNT_W'(CAPACITY));
  assign sts.empty     = (count_r == '0);
  assign sts.at_root   = (pos_r == '0);
  assign sts.up_swap   = mover_r[COST_WIDTH-1:0] < rdata[COST_WIDTH-1:0];
  assign sts.has_left  = left < CHD_W'(count_r);
  assign sts.down_swap = pick_ent[COST_WIDTH-1:0] < mover_r[COST_WIDTH-1:0];

  always_comb begin
    raddr = '0;
    if (cmd.rd_parent) begin
      raddr = parent;
    end else if (cmd.pop_last) begin
      raddr = count_r[IDX_W-1:0];
    end else if (cmd.rd_left) begin
      raddr = left[IDX_W-1:0];
    end else if (cmd.rd_right) begin
      raddr = right[IDX_W-1:0];
    end
  end

  assign we = cmd.move_up | cmd.move_down | cmd.place;

  always_comb begin
    wdata = mover_r;
    if (cmd.move_up) begin
      wdata = rdata;
    end else if (cmd.move_down) begin
      wdata = pick_ent;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.finish;
      if (cmd.take_push) begin
        count_r <= count_r + CNT_W'(1);
      end else if (cmd.take_pop) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_push) begin
      pos_r      <= count_r[IDX_W-1:0];
      mover_r    <= new_ent;
      res_ent_r  <= '0;
      res_code_r <= ST_DONE;
    end
    if (cmd.take_pop) begin
      res_code_r <= ST_DONE;
    end
    if (cmd.take_reject) begin
      res_ent_r  <= '0;
      res_code_r <= sts.req_pop ? ST_EMPTY : ST_FULL;
    end
    if (cmd.move_up) begin
      pos_r <= parent;
    end
    if (cmd.pop_last) begin
      res_ent_r <= rdata;
    end
    if (cmd.load_last) begin
      mover_r <= rdata;
      pos_r   <= '0;
    end
    if (cmd.rd_right) begin
      child_r <= rdata;
    end
    if (cmd.move_down) begin
      pos_r <= pick_idx;
    end
    if (cmd.finish) begin
      out_item_r.out_x       <= IN_COORD_W'(res_ent_r[X_LSB +: COORD_WIDTH]);
      out_item_r.out_y       <= IN_COORD_W'(res_ent_r[Y_LSB +: COORD_WIDTH]);
      out_item_r.out_z       <= IN_COORD_W'(res_ent_r[Z_LSB +: COORD_WIDTH]);
      out_item_r.out_cost    <= IN_COST_W'(res_ent_r[COST_WIDTH-1:0]);
      out_item_r.status      <= res_code_r;
      out_item_r.count_after <= COUNT_W'(count_r);
      out_item_r.is_empty    <= (count_r == '0);
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

// ----- rtl/binary_min_heap_queue_core.sv -----
// Binary min-heap priority queue of points keyed on cost.
// A push sifts the new item up and a pop sifts the last item down, one level at a time,
// through the one read port of the heap RAM: a parent read and a compare per level going
// up, a left-child read, a right-child read and a compare per level going down.
// One item is processed at a time; busy drops in the cycle the result is shown.
// Synchronous reset empties the heap at once; the result cannot be stalled.
module binary_min_heap_queue_core
  import bmhq_pkg::*;
#(
  parameter int unsigned CAPACITY    = 1024,
  parameter int unsigned COORD_WIDTH = 16,
  parameter int unsigned COST_WIDTH  = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item,
  output logic      out_valid,
  output out_item_t out_item
);

  cmd_t cmd;
  sts_t sts;

  bmhq_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  bmhq_dp #(
    .CAPACITY    (CAPACITY),
    .COORD_WIDTH (COORD_WIDTH),
    .COST_WIDTH  (COST_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

// ----- dv/binary_min_heap_queue_core_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for binary_min_heap_queue_core: push and pop requests
// are checked against an in-bench heap predictor, with random gaps between items.
// Depends on bmhq_pkg and the core RTL only.
module binary_min_heap_queue_core_tb
  import bmhq_pkg::*;
();

  localparam int unsigned CAPACITY    = 1024;
  localparam int unsigned ITEM_TARGET = 1650;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned DRAIN_WAIT  = 64;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  in_item_t  in_item = '0;
  logic      out_valid;
  out_item_t out_item;

  binary_min_heap_queue_core #(
    .CAPACITY   (CAPACITY),
    .COORD_WIDTH(16),
    .COST_WIDTH (32)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  in_item_t    req_q[$];
  out_item_t   heap_replies[$];
  logic [31:0] key_mem [CAPACITY];
  logic [47:0] point_mem [CAPACITY];
  int unsigned held = 0;
  int unsigned gen_held = 0;
  int unsigned issue_cnt = 0;
  int unsigned accept_cnt = 0;
  int unsigned gap_left = 0;
  int unsigned calm_left = 0;
  int unsigned stall_cycles = 0;
  int unsigned err_cnt = 0;
  int unsigned n_push = 0;
  int unsigned n_pop = 0;
  int unsigned n_full = 0;
  int unsigned n_empty = 0;
  int unsigned peak_held = 0;

  function automatic void swap_slots(int unsigned a, int unsigned b);
    logic [31:0] k;
    logic [47:0] p;
    k = key_mem[a];
    p = point_mem[a];
    key_mem[a] = key_mem[b];
    point_mem[a] = point_mem[b];
    key_mem[b] = k;
    point_mem[b] = p;
  endfunction

  function automatic out_item_t heap_apply(in_item_t it);
    out_item_t   r;
    int unsigned at, up, kid, pick, last;
    r = '0;
    if (it.req_type == REQ_PUSH) begin
      if (held >= CAPACITY) begin
        r.status = ST_FULL;
      end else begin
        at = held;
        key_mem[at] = it.point_cost;
        point_mem[at] = {it.point_x, it.point_y, it.point_z};
        held = held + 1;
        while (at != 0) begin
          up = (at - 1) / 2;
          if (key_mem[at] < key_mem[up]) begin
            swap_slots(at, up);
            at = up;
          end else begin
            break;
          end
        end
      end
    end else begin
      if (held == 0) begin
        r.status = ST_EMPTY;
      end else begin
        r.out_x = point_mem[0][47:32];
        r.out_y = point_mem[0][31:16];
        r.out_z = point_mem[0][15:0];
        r.out_cost = key_mem[0];
        last = held - 1;
        key_mem[0] = key_mem[last];
        point_mem[0] = point_mem[last];
        held = last;
        at = 0;
        forever begin
          kid = 2 * at + 1;
          if (kid >= held) break;
          pick = kid;
          if (kid + 1 < held && key_mem[kid + 1] < key_mem[kid]) pick = kid + 1;
          if (key_mem[pick] < key_mem[at]) begin
            swap_slots(at, pick);
            at = pick;
          end else begin
            break;
          end
        end
      end
    end
    r.count_after = held[COUNT_W-1:0];
    r.is_empty = (held == 0);
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
      err_cnt++;
    end
  endtask

  task automatic queue_fixed(input logic kind, input logic [15:0] x, input logic [15:0] y,
                             input logic [15:0] z, input logic [31:0] cost);
    in_item_t it;
    it.req_type = kind;
    it.point_x = x;
    it.point_y = y;
    it.point_z = z;
    it.point_cost = cost;
    req_q.push_back(it);
    if (kind == REQ_PUSH) begin
      if (gen_held < CAPACITY) gen_held++;
    end else if (gen_held > 0) begin
      gen_held--;
    end
  endtask

  function automatic logic [31:0] rand_cost();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return 32'h0;
    if (r == 1) return 32'hFFFF_FFFF;
    if (r < 5) return $urandom_range(0, 7);
    return $urandom;
  endfunction

  task automatic queue_random(input int unsigned push_pct);
    logic kind;
    kind = ($urandom_range(0, 99) < push_pct) ? REQ_PUSH : REQ_POP;
    queue_fixed(kind, 16'($urandom), 16'($urandom), 16'($urandom), rand_cost());
  endtask

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) begin
      calm_left = $urandom_range(20, 80);
      return 0;
    end
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  always @(negedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
      in_item <= '0;
    end else if (!start || accept_cnt == issue_cnt) begin
      if (gap_left > 0) begin
        start <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (req_q.size() > 0) begin
        in_item <= req_q.pop_front();
        start <= 1'b1;
        issue_cnt <= issue_cnt + 1;
        gap_left <= pick_gap();
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : monitor
    out_item_t want, pred;
    logic      progress;
    progress = 1'b0;
    if (rst_n) begin
      if (out_valid === 1'b1) begin
        progress = 1'b1;
        if (heap_replies.size() == 0) begin
          $error("result item with no request outstanding");
          err_cnt++;
        end else begin
          want = heap_replies.pop_front();
          check_field("out_x", want.out_x, out_item.out_x);
          check_field("out_y", want.out_y, out_item.out_y);
          check_field("out_z", want.out_z, out_item.out_z);
          check_field("out_cost", want.out_cost, out_item.out_cost);
          check_field("status", want.status, out_item.status);
          check_field("count_after", want.count_after, out_item.count_after);
          check_field("is_empty", want.is_empty, out_item.is_empty);
        end
      end
      if (start && !busy) begin
        progress = 1'b1;
        pred = heap_apply(in_item);
        heap_replies.push_back(pred);
        accept_cnt <= accept_cnt + 1;
        if (in_item.req_type == REQ_PUSH) n_push++;
        else n_pop++;
        if (pred.status == ST_FULL) n_full++;
        if (pred.status == ST_EMPTY) n_empty++;
        if (held > peak_held) peak_held = held;
      end
      if (progress) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
          $display("CHECK FAILED");
          $finish;
        end
      end
    end
  end

  initial begin
    // Directed opening: empty pop, extreme points, cost ties, full drain.
    queue_fixed(REQ_POP, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
    queue_fixed(REQ_PUSH, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
    queue_fixed(REQ_PUSH, 16'h0000, 16'h0000, 16'h0000, 32'h0000_0000);
    queue_fixed(REQ_PUSH, 16'h0001, 16'h0002, 16'h0003, 32'h0001_0000);
    queue_fixed(REQ_PUSH, 16'h0004, 16'h0005, 16'h0006, 32'h0001_0000);
    queue_fixed(REQ_PUSH, 16'hAAAA, 16'h5555, 16'hA5A5, 32'h0000_8000);
    queue_fixed(REQ_PUSH, 16'h0007, 16'h0008, 16'h0009, 32'h0001_0000);
    queue_fixed(REQ_PUSH, 16'hFFFF, 16'h0000, 16'hFFFF, 32'h7FFF_FFFF);
    repeat (7) queue_fixed(REQ_POP, 16'h0, 16'h0, 16'h0, 32'h0);
    queue_fixed(REQ_POP, 16'h5A5A, 16'hA5A5, 16'h0F0F, 32'h8000_0000);
    for (int i = 0; i < 3; i++) begin
      queue_fixed(REQ_PUSH, 16'(16'h1000 + i), 16'(16'h2000 + i), 16'(16'h3000 + i),
                  32'h0000_0042);
    end
    repeat (4) queue_fixed(REQ_POP, 16'h0, 16'h0, 16'h0, 32'h0);

    repeat (200) queue_random(50);
    while (gen_held < CAPACITY) queue_random(90);
    repeat (16) queue_random(75);
    while (req_q.size() < ITEM_TARGET) queue_random(15);

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    while (req_q.size() != 0 || accept_cnt != issue_cnt || heap_replies.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("Ran %0d pushes and %0d pops; %0d pushes dropped on a full heap,",
             n_push, n_pop, n_full);
    $display("%0d pops of an empty heap; peak occupancy was %0d of %0d entries.",
             n_empty, peak_held, CAPACITY);
    if (err_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
